>>> rtl/sle_pkg.sv
package sle_pkg;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_ZERO   = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Result queue geometry; the depth must stay a power of two.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       bad;
    logic       fin;
  } res_t;

  // Up to two results produced by one input byte.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  // Returns the decoded value of a simple escape, zero when the letter is none.
  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h27:   r = 8'h27;
      8'h22:   r = 8'h22;
      8'h5C:   r = 8'h5C;
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = 8'd27;
      8'h66:   r = 8'd12;
      8'h6E:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Returns {is_digit, value} for one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic res_t mk_char(input logic [7:0] ch, input logic bad);
    res_t r;
    r.ch    = ch;
    r.valid = 1'b1;
    r.bad   = bad;
    r.fin   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_end();
    res_t r;
    r.ch    = CH_NUL;
    r.valid = 1'b0;
    r.bad   = 1'b0;
    r.fin   = 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/sle_decode.sv
module sle_decode
  import sle_pkg::*;
(
  input  mode_t      mode,
  input  logic [7:0] acc,
  input  logic       await_open,
  input  logic [7:0] ch,
  input  logic       last,
  output mode_t      mode_nxt,
  output logic [7:0] acc_nxt,
  output logic       await_nxt,
  output dec_out_t   dec
);

  logic [7:0] esc_val;
  logic [4:0] hex_d;

  assign esc_val = simple_escape(ch);
  assign hex_d   = hex_digit(ch);

  // Next state.
  always_comb begin
    mode_nxt  = mode;
    acc_nxt   = acc;
    await_nxt = await_open;
    if (await_open) begin
      await_nxt = last;
    end else if (last) begin
      mode_nxt  = MODE_NORMAL;
      acc_nxt   = 8'd0;
      await_nxt = 1'b1;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          if (ch == CH_BSLASH) mode_nxt = MODE_ESC;
        end
        MODE_ESC: begin
          if (esc_val == 8'd0 && ch == CH_ZERO) mode_nxt = MODE_ZERO;
          else mode_nxt = MODE_NORMAL;
        end
        MODE_ZERO: begin
          if (ch == CH_X) begin
            acc_nxt  = 8'd0;
            mode_nxt = MODE_HEX;
          end else begin
            mode_nxt = (ch == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
          end
        end
        MODE_HEX: begin
          if (hex_d[4]) begin
            acc_nxt = {acc[3:0], hex_d[3:0]};
          end else begin
            acc_nxt  = 8'd0;
            mode_nxt = (ch == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
          end
        end
        default: mode_nxt = MODE_NORMAL;
      endcase
    end
  end

  // Results.
  always_comb begin
    dec.num = 2'd0;
    dec.r0  = mk_end();
    dec.r1  = mk_end();
    if (await_open) begin
      if (last) dec.num = 2'd1;
    end else if (last) begin
      case (mode)
        MODE_ESC, MODE_ZERO: begin
          dec.num = 2'd2;
          dec.r0  = mk_char(CH_SPACE, 1'b1);
        end
        MODE_HEX: begin
          dec.num = 2'd2;
          dec.r0  = mk_char(acc, 1'b0);
        end
        default: dec.num = 2'd1;
      endcase
    end else begin
      case (mode)
        MODE_NORMAL: begin
          if (ch != CH_BSLASH) begin
            dec.num = 2'd1;
            dec.r0  = mk_char(ch, 1'b0);
          end
        end
        MODE_ESC: begin
          if (esc_val != 8'd0) begin
            dec.num = 2'd1;
            dec.r0  = mk_char(esc_val, 1'b0);
          end else if (ch != CH_ZERO) begin
            dec.num = 2'd1;
            dec.r0  = mk_char(CH_SPACE, 1'b1);
          end
        end
        MODE_ZERO: begin
          if (ch != CH_X) begin
            dec.r0  = mk_char(CH_SPACE, 1'b1);
            dec.r1  = mk_char(ch, 1'b0);
            dec.num = (ch == CH_BSLASH) ? 2'd1 : 2'd2;
          end
        end
        MODE_HEX: begin
          if (!hex_d[4]) begin
            dec.r0  = mk_char(acc, 1'b0);
            dec.r1  = mk_char(ch, 1'b0);
            dec.num = (ch == CH_BSLASH) ? 2'd1 : 2'd2;
          end
        end
        default: dec.num = 2'd0;
      endcase
    end
  end

endmodule

>>> rtl/sle_out_fifo.sv
module sle_out_fifo
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  dec_out_t         wr,
  input  logic             rd_en,
  output res_t             head,
  output logic [CNT_W-1:0] cnt
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_in;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign n_in      = wr_en ? CNT_W'(wr.num) : '0;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_in);
    rd_ptr_nxt = rd_ptr_r + (rd_en ? PTR_W'(1) : '0);
    cnt_nxt    = cnt_r + n_in - (rd_en ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr.num != 2'd0) mem[wr_ptr_r] <= wr.r0;
    if (wr_en && wr.num == 2'd2) mem[wr_ptr_p1] <= wr.r1;
  end

  assign head = mem[rd_ptr_r];
  assign cnt  = cnt_r;

endmodule

>>> rtl/string_literal_unescaper.sv
// Channel  Ports                                                   Direction
// in       in_valid, in_stall, in_char_in, in_is_last              request in
// out      out_valid, out_stall, out_char_out, out_char_valid,     request out
//          out_illegal_escape, out_string_end
//
// A byte request is taken into an input register and decoded from there. Its zero, one
// or two results are written into a four-entry result queue at the next edge that finds
// at most two entries queued.
// One byte per cycle is sustained while the queue drains one result per cycle. Each byte
// that yields two results leaves one more entry queued, and once three are queued the
// next byte holds in_stall for a cycle; out_stall backs the queue up the same way.
// A byte passes through the input register and then the result queue before its first result shows.
// Reset (rst_n low, synchronous) empties the queue, clears the input register
// and returns the decoder to waiting for an opening quote.
// in_stall depends only on registered state, never on out_stall in the same cycle.
module string_literal_unescaper
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_char_valid,
  output logic       out_illegal_escape,
  output logic       out_string_end
);

  // Input register: holds one accepted byte until the queue has room for two results.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // Decoder state.
  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       await_r, await_nxt;

  dec_out_t         dec;
  res_t             head;
  logic [CNT_W-1:0] q_cnt;
  logic             room;
  logic             consume;
  logic             accept_in;
  logic             pop;

  // The worst case byte adds two results, so the queue must have two free slots.
  assign room      = q_cnt <= CNT_W'(FIFO_DEPTH - 2);
  assign consume   = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign accept_in = in_valid && !in_stall;
  assign out_valid = q_cnt != '0;
  assign pop       = out_valid && !out_stall;

  assign in_vld_nxt = accept_in ? 1'b1 : (consume ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= MODE_NORMAL;
      acc_r    <= 8'd0;
      await_r  <= 1'b1;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (consume) begin
        mode_r  <= mode_nxt;
        acc_r   <= acc_nxt;
        await_r <= await_nxt;
      end
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_char_r <= in_char_in;
      in_last_r <= in_is_last;
    end
  end

  sle_decode u_decode (
    .mode       (mode_r),
    .acc        (acc_r),
    .await_open (await_r),
    .ch         (in_char_r),
    .last       (in_last_r),
    .mode_nxt   (mode_nxt),
    .acc_nxt    (acc_nxt),
    .await_nxt  (await_nxt),
    .dec        (dec)
  );

  sle_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (consume),
    .wr    (dec),
    .rd_en (pop),
    .head  (head),
    .cnt   (q_cnt)
  );

  assign out_char_out       = head.ch;
  assign out_char_valid     = head.valid;
  assign out_illegal_escape = head.bad;
  assign out_string_end     = head.fin;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("stall raised with an empty input register");

  a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == '0 && !consume) |=> !out_valid)
    else $error("result appeared without a decode");

  a_hex_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_last_r) |=> (mode_r == MODE_NORMAL && acc_r == 8'd0 && await_r))
    else $error("closing byte did not restore idle decode state");
`endif

endmodule
